FILE: hdl/spq_pkg.sv
// Package for the sorted priority queue: transaction codes, status codes
// and the command struct broadcast from the top level to every cell.
// No dependencies.
package spq_pkg;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_POPPED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int VALUE_BITS = 32;
   localparam int PRIO_BITS  = 8;

   typedef struct packed {
      logic                   insert;
      logic                   pop;
      logic [VALUE_BITS-1:0]  value;
      logic [PRIO_BITS-1:0]   prio;
   } spq_cmd_type;

endpackage

FILE: hdl/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Holds one entry, compares it with the broadcast priority and takes
// from its left or right neighbor. Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
#(
   parameter int PW = 8
) (
   input  logic                  clock,
   input  spq_cmd_type           cmd,
   input  logic                  occupied,
   input  logic                  prev_after,
   input  logic [VALUE_BITS-1:0] prev_value,
   input  logic [PW-1:0]         prev_prio,
   input  logic [VALUE_BITS-1:0] next_value,
   input  logic [PW-1:0]         next_prio,
   output logic                  goes_after,
   output logic [VALUE_BITS-1:0] value,
   output logic [PW-1:0]         prio
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [PW-1:0]         prio_ff, prio_in;

   assign goes_after = occupied && (prio_ff <= cmd.prio[PW-1:0]);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.insert && !goes_after) begin
         if (prev_after) begin
            value_in = cmd.value;
            prio_in  = cmd.prio[PW-1:0];
         end else begin
            value_in = prev_value;
            prio_in  = prev_prio;
         end
      end else if (cmd.pop) begin
         value_in = next_value;
         prio_in  = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

FILE: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of CAPACITY cells kept in priority order.
// The result of a transaction is registered and presented in the cycle after acceptance.
// Throughput: one insert or pop per cycle while req_stall is low; every cell updates in parallel.
// Reset clears the fill count and the response valid; cell contents are
// left undefined and need no clearing pass. Depends on spq_pkg, spq_cell.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic signed [31:0]    req_item_value,
   input  logic [7:0]            req_item_priority,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_out_value,
   output logic [7:0]            rsp_out_priority,
   output logic [4:0]            rsp_occupancy
);

   localparam int PW = (PRIORITY_BITS < PRIO_BITS) ? PRIORITY_BITS : PRIO_BITS;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     value_ff, value_in;
   logic [7:0]      prio_ff, prio_in;

   logic            accept, full, empty;
   spq_cmd_type     cmd;

   logic [CAPACITY-1:0]   after;
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic [PW-1:0]         cell_prio  [CAPACITY];

   logic [PW+7:0]   head_prio_ext;
   logic [CW+4:0]   occ_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd.insert = accept && (req_kind == KIND_INSERT) && !full;
      cmd.pop    = accept && (req_kind == KIND_POP) && !empty;
      cmd.value  = req_item_value;
      cmd.prio   = req_item_priority;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                  occ;
         logic                  left_after;
         logic [VALUE_BITS-1:0] left_value, right_value;
         logic [PW-1:0]         left_prio, right_prio;

         assign occ = (CW'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign left_after = 1'b1;
            assign left_value = cell_value[0];
            assign left_prio  = cell_prio[0];
         end else begin : g_mid
            assign left_after = after[gi-1];
            assign left_value = cell_value[gi-1];
            assign left_prio  = cell_prio[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[gi];
            assign right_prio  = cell_prio[gi];
         end else begin : g_inner
            assign right_value = cell_value[gi+1];
            assign right_prio  = cell_prio[gi+1];
         end

         spq_cell #(
            .PW(PW)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occ),
            .prev_after (left_after),
            .prev_value (left_value),
            .prev_prio  (left_prio),
            .next_value (right_value),
            .next_prio  (right_prio),
            .goes_after (after[gi]),
            .value      (cell_value[gi]),
            .prio       (cell_prio[gi])
         );
      end
   endgenerate

   assign head_prio_ext = {8'b0, cell_prio[0]};

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      value_in     = value_ff;
      prio_in      = prio_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         prio_in      = '0;
         if (req_kind == KIND_INSERT) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_INSERTED;
               count_in  = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_POPPED;
               value_in  = cell_value[0];
               prio_in   = head_prio_ext[7:0];
               count_in  = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      prio_ff   <= prio_in;
   end

   assign occ_ext          = {5'b0, count_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = value_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_occupancy    = occ_ext[4:0];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_pop_empty : assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_POP && empty |=>
         status_ff == ST_EMPTY && count_ff == '0 && value_ff == '0)
      else $error("pop on empty queue changed state or reported wrong status");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_INSERT && !full |=>
         count_ff == $past(count_ff) + 1'b1 && status_ff == ST_INSERTED)
      else $error("insert did not advance fill count");

   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_INSERT && full |=>
         status_ff == ST_FULL && count_ff == CW'(CAPACITY))
      else $error("insert into full queue not rejected");

endmodule

FILE: test/sorted_priority_queue_unit_test.sv
// Self-checking testbench for sorted_priority_queue_unit: directed and random insert and
// pop transactions are checked against a sorted-store model, with random gaps and stalls.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL.
module sorted_priority_queue_unit_test
   import spq_pkg::*;
;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS  = 600;
   localparam int CALM_FIRST  = 250;
   localparam int CALM_LAST   = 400;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] value;
      logic [7:0]        prio;
   } queue_op_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [31:0] value;
      logic [7:0]        prio;
      logic [4:0]        occupancy;
   } queue_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = KIND_INSERT;
   logic signed [31:0] req_item_value = '0;
   logic [7:0]         req_item_priority = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_value;
   logic [7:0]         rsp_out_priority;
   logic [4:0]         rsp_occupancy;

   queue_op_type     pending_ops[$];
   queue_result_type expected_results[$];

   logic signed [31:0] slot_value [SLOTS];
   logic [7:0]         slot_prio [SLOTS];
   int                 held = 0;

   int gen_held = 0;
   int items_sent = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int err_count = 0;
   int n_inserted = 0;
   int n_popped = 0;
   int n_empty = 0;
   int n_full = 0;

   sorted_priority_queue_unit #(
      .CAPACITY      (SLOTS),
      .PRIORITY_BITS (8)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sorted store: ties go behind existing entries of equal priority.
   function automatic queue_result_type queue_apply(queue_op_type op);
      queue_result_type r;
      int pos;
      int i;
      r = '0;
      if (op.kind == KIND_INSERT) begin
         if (held >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < held && slot_prio[pos] <= op.prio) pos++;
            for (i = held; i > pos; i--) begin
               slot_value[i] = slot_value[i-1];
               slot_prio[i]  = slot_prio[i-1];
            end
            slot_value[pos] = op.value;
            slot_prio[pos]  = op.prio;
            held++;
            r.status = ST_INSERTED;
         end
      end else begin
         if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.value = slot_value[0];
            r.prio  = slot_prio[0];
            for (i = 1; i < held; i++) begin
               slot_value[i-1] = slot_value[i];
               slot_prio[i-1]  = slot_prio[i];
            end
            held--;
            r.status = ST_POPPED;
         end
      end
      r.occupancy = 5'(held);
      return r;
   endfunction

   function automatic logic take_break();
      if (items_sent >= CALM_FIRST && items_sent < CALM_LAST) return 1'b0;
      return $urandom_range(99) < 22;
   endfunction

   function automatic logic [7:0] pick_prio(int mode);
      case (mode)
         0: return 8'($urandom_range(255));
         1: return 8'($urandom_range(3));
         default: return ($urandom_range(1) != 0) ? 8'hff : 8'h00;
      endcase
   endfunction

   task automatic add_insert(logic signed [31:0] value, logic [7:0] prio);
      pending_ops.push_back('{kind: KIND_INSERT, value: value, prio: prio});
      if (gen_held < SLOTS) gen_held++;
   endtask

   task automatic add_pop();
      pending_ops.push_back('{kind: KIND_POP, value: $urandom, prio: 8'($urandom_range(255))});
      if (gen_held > 0) gen_held--;
   endtask

   always @(posedge clock) begin : drive_proc
      queue_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            op = '{kind: req_kind, value: req_item_value, prio: req_item_priority};
            expected_results.push_back(queue_apply(op));
            items_sent <= items_sent + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_ops.size() > 0 && !take_break()) begin
               op = pending_ops.pop_front();
               req_valid         <= 1'b1;
               req_kind          <= op.kind;
               req_item_value    <= op.value;
               req_item_priority <= op.prio;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : stall_proc
      int hold_left;
      logic hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 120) begin
         hold_done = 1'b1;
         hold_left = 60;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= take_break();
      end
   end

   always @(posedge clock) begin : check_proc
      queue_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: status %0d", rsp_status);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            case (want.status)
               ST_INSERTED: n_inserted++;
               ST_POPPED:   n_popped++;
               ST_EMPTY:    n_empty++;
               default:     n_full++;
            endcase
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
               err_count++;
            end
            if (rsp_out_priority !== want.prio) begin
               $error("out_priority: expected %0d, got %0d", want.prio, rsp_out_priority);
               err_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sorted_priority_queue_unit_test: FAIL");
         $finish;
      end
   end

   initial begin : run_proc
      int made;
      int mode;
      int n;
      int k;

      add_pop();
      add_insert(32'sh7fffffff, 8'hff);
      add_insert(32'sh80000000, 8'h00);
      add_insert(-32'sd1, 8'h00);
      add_insert(32'sd0, 8'hff);
      add_insert(32'sh55555555, 8'haa);
      add_insert(32'shaaaaaaaa, 8'h55);
      for (k = 0; k < 7; k++) add_pop();

      made = 0;
      while (made < RANDOM_OPS) begin
         mode = $urandom_range(2);
         case ($urandom_range(9))
            0, 1, 2: begin
               n = SLOTS - gen_held + $urandom_range(1, 3);
               for (k = 0; k < n; k++) add_insert($urandom, pick_prio(mode));
            end
            3, 4: begin
               n = gen_held + $urandom_range(1, 2);
               for (k = 0; k < n; k++) add_pop();
            end
            default: begin
               n = $urandom_range(10, 30);
               for (k = 0; k < n; k++) begin
                  if ($urandom_range(1) == 0) add_insert($urandom, pick_prio(mode));
                  else add_pop();
               end
            end
         endcase
         made += n;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d transactions: %0d inserted, %0d popped", results_seen,
               n_inserted, n_popped);
      $display("special cases: %0d rejected when full, %0d pops on empty", n_full, n_empty);
      if (err_count == 0) begin
         $display("sorted_priority_queue_unit_test: PASS");
      end else begin
         $display("sorted_priority_queue_unit_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
test/sorted_priority_queue_unit_test.sv
